// ===== rtl/core/cfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types, constants and the crc helper for the command frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int CHANNELS_DEF = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [5:0] POS_MAX    = 6'd63;
    localparam logic [5:0] POS_FIRST_OFFSET = 6'd16;

    typedef enum logic [1:0] {
        REG_HEAD    = 2'd0,
        REG_TYPE    = 2'd1,
        REG_VERSION = 2'd2,
        REG_FLAGS   = 2'd3
    } cfr_reg_index_t;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_FETCH,
        ST_LOAD
    } cfr_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } cfr_in_t;

    typedef struct packed {
        logic               accepted;
        logic [7:0]         flag_bits;
        logic [31:0]        boot_ident;
        logic [31:0]        session_ident;
        logic [31:0]        sequence_number;
        logic [3:0]         channel_index;
        logic signed [15:0] channel_offset;
        logic               last_result;
    } cfr_out_t;

    // msb-first ccitt update over one byte
    function automatic logic [15:0] crc_absorb(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/core/cfr_offset_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_offset_ram
// Channel offset store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cfr_offset_ram #(
    parameter int DEPTH  = cfr_pkg::CHANNELS_DEF,
    parameter int ADDR_W = 3
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [15:0]       wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [15:0]       rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/command_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_receiver
// Parses crc-checked command frames into per-channel words or a reject word.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one frame byte per word, frame_end set on the final byte.
//   Bytes are taken one per cycle while collecting and the output is free.
//   cfg_* writes the head, type, version and flag mask registers; write
//   only while no frame is in progress and no result is outstanding.
//   m_* delivers results through a single output register. A rejected
//   frame gives one word with accepted low, loaded in the cycle after the
//   final byte. An accepted frame gives CHANNELS words; the offset ram is
//   read one entry at a time, each through a fetch state (ram read) and a
//   load state into the output register, which waits while that register
//   is still full and m_ready is low. s_ready is low while these words are
//   produced, and also while a finished word waits in the output register
//   and m_ready is low.
//   Reset clears the byte counter, crc, registers and the output valid;
//   the offset ram is not cleared, an accepted frame always refills it.
// ----------------------------------------------------------------------------
module command_frame_receiver #(
    parameter int CHANNELS = cfr_pkg::CHANNELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  cfr_pkg::cfr_in_t  s_data,

    output logic              m_valid,
    input  logic              m_ready,
    output cfr_pkg::cfr_out_t m_data,

    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_wr_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [5:0] FRAME_LEN = 6'(18 + 2 * CHANNELS);
    localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

    // configuration registers
    logic [7:0] head_reg, type_reg, version_reg, mask_reg;

    // frame state
    cfr_pkg::cfr_state_t state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  tb0_reg, tb1_reg;
    logic        hdr_good_reg, hdr_good_next;
    logic [7:0]  flags_reg;
    logic [31:0] boot_reg, session_reg, seq_reg;
    logic [7:0]  low_hold_reg;
    logic [IDX_W-1:0] drain_idx_reg;

    // output register
    logic              m_valid_reg;
    cfr_pkg::cfr_out_t m_data_reg, out_data;

    logic        in_acc, out_free, out_load, frame_ok, drain_last;
    logic [7:0]  b;
    logic [5:0]  off;
    logic [4:0]  ch;
    logic        ram_we;
    logic [15:0] ram_rdata;
    logic [15:0] rx_crc;

    assign b          = s_data.data_byte;
    assign in_acc     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign drain_last = (drain_idx_reg == IDX_LAST);
    assign off        = pos_reg - cfr_pkg::POS_FIRST_OFFSET;
    assign ch         = off[5:1];
    assign ram_we     = in_acc && (pos_reg >= cfr_pkg::POS_FIRST_OFFSET)
                        && (ch < CH_LIMIT) && off[0];

    // per-byte datapath
    always_comb begin
        pos_next = (pos_reg < cfr_pkg::POS_MAX) ? pos_reg + 6'd1 : pos_reg;
        crc_next = (pos_reg >= 6'd2) ? cfr_pkg::crc_absorb(crc_reg, tb0_reg) : crc_reg;
        hdr_good_next = hdr_good_reg;
        case (pos_reg)
            6'd0: if (b != head_reg) hdr_good_next = 1'b0;
            6'd1: if (b != type_reg) hdr_good_next = 1'b0;
            6'd2: if (b != version_reg) hdr_good_next = 1'b0;
            6'd3: if ((b & ~mask_reg) != 8'h00) hdr_good_next = 1'b0;
            default: hdr_good_next = hdr_good_reg;
        endcase
        // expected crc sits in the last two bytes, low byte first
        rx_crc   = {b, tb1_reg};
        frame_ok = (pos_next == FRAME_LEN) && hdr_good_next && (rx_crc == crc_next);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cfr_pkg::ST_RECV: begin
                if (in_acc && s_data.frame_end && frame_ok) state_next = cfr_pkg::ST_FETCH;
            end
            cfr_pkg::ST_FETCH: state_next = cfr_pkg::ST_LOAD;
            cfr_pkg::ST_LOAD: begin
                if (out_free) begin
                    state_next = drain_last ? cfr_pkg::ST_RECV : cfr_pkg::ST_FETCH;
                end
            end
            default: state_next = cfr_pkg::ST_RECV;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        out_data = '0;
        unique case (state_reg)
            cfr_pkg::ST_RECV: begin
                s_ready = out_free;
                // reject word
                out_load = in_acc && s_data.frame_end && !frame_ok;
                out_data.last_result = 1'b1;
            end
            cfr_pkg::ST_FETCH: begin
                out_load = 1'b0;
            end
            cfr_pkg::ST_LOAD: begin
                out_load                 = out_free;
                out_data.accepted        = 1'b1;
                out_data.flag_bits       = flags_reg;
                out_data.boot_ident      = boot_reg;
                out_data.session_ident   = session_reg;
                out_data.sequence_number = seq_reg;
                out_data.channel_index   = 4'(drain_idx_reg);
                out_data.channel_offset  = ram_rdata;
                out_data.last_result     = drain_last;
            end
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= 8'h00;
            type_reg    <= 8'h00;
            version_reg <= 8'h00;
            mask_reg    <= 8'h01;
        end else if (cfg_wr_en) begin
            unique case (cfr_pkg::cfr_reg_index_t'(cfg_index))
                cfr_pkg::REG_HEAD:    head_reg    <= cfg_wr_data;
                cfr_pkg::REG_TYPE:    type_reg    <= cfg_wr_data;
                cfr_pkg::REG_VERSION: version_reg <= cfg_wr_data;
                cfr_pkg::REG_FLAGS:   mask_reg    <= cfg_wr_data;
                default:              mask_reg    <= mask_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cfr_pkg::ST_RECV;
            pos_reg       <= 6'd0;
            crc_reg       <= cfr_pkg::CRC_INIT;
            tb0_reg       <= 8'h00;
            tb1_reg       <= 8'h00;
            hdr_good_reg  <= 1'b1;
            drain_idx_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_acc) begin
                if (s_data.frame_end) begin
                    pos_reg      <= 6'd0;
                    crc_reg      <= cfr_pkg::CRC_INIT;
                    tb0_reg      <= 8'h00;
                    tb1_reg      <= 8'h00;
                    hdr_good_reg <= 1'b1;
                end else begin
                    pos_reg      <= pos_next;
                    crc_reg      <= crc_next;
                    tb0_reg      <= tb1_reg;
                    tb1_reg      <= b;
                    hdr_good_reg <= hdr_good_next;
                end
            end
            if (state_reg == cfr_pkg::ST_RECV) begin
                drain_idx_reg <= '0;
            end else if (state_reg == cfr_pkg::ST_LOAD && out_free) begin
                drain_idx_reg <= drain_idx_reg + IDX_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // held header fields, little-endian
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            if (pos_reg == 6'd3) flags_reg <= b;
            unique case (pos_reg[5:2])
                4'd1: boot_reg[pos_reg[1:0]*8 +: 8]    <= b;
                4'd2: session_reg[pos_reg[1:0]*8 +: 8] <= b;
                4'd3: seq_reg[pos_reg[1:0]*8 +: 8]     <= b;
                default: ;
            endcase
            if (!off[0]) low_hold_reg <= b;
        end
        if (out_load) begin
            m_data_reg <= out_data;
        end
    end

    cfr_offset_ram #(
        .DEPTH  (CHANNELS),
        .ADDR_W (IDX_W)
    ) u_offset_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ch[IDX_W-1:0]),
        .wr_data ({b, low_hold_reg}),
        .rd_addr (drain_idx_reg),
        .rd_data (ram_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // the ram is only written while bytes are collected
    a_no_write_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != cfr_pkg::ST_RECV) |-> !ram_we)
        else $error("offset ram written while results are produced");

    a_restart_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_data.frame_end) |=> (pos_reg == 6'd0) && (crc_reg == cfr_pkg::CRC_INIT)
            && hdr_good_reg)
        else $error("frame state not restarted after final byte");

    a_reject_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.accepted) |-> m_data.last_result && (m_data.channel_index == 4'd0))
        else $error("reject word malformed");

    a_last_back_to_recv: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.accepted && m_data.last_result) |-> (state_reg == cfr_pkg::ST_RECV))
        else $error("final word shown while still draining");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != cfr_pkg::ST_RECV) |-> (32'(drain_idx_reg) < CHANNELS))
        else $error("drain index past channel count");

    a_load_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("output register overwritten");

endmodule

// ===== sim/command_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_receiver_tb
// Self-checking bench for the command frame receiver. Builds frames byte by
// byte (good frames with random content plus header, flag, crc, length and
// noise faults), predicts the channel or reject words for every frame and
// compares each delivered word field by field, with random idling on both
// channels and several register settings.
// ----------------------------------------------------------------------------
module command_frame_receiver_tb;

    localparam int CHANNELS = cfr_pkg::CHANNELS_DEF;
    localparam int PHASES = 4;
    localparam int PHASE_BYTES = 70;

    typedef enum int {
        FK_GOOD,
        FK_BAD_HEAD,
        FK_BAD_TYPE,
        FK_BAD_VERSION,
        FK_BAD_FLAGS,
        FK_BAD_CRC,
        FK_SHORT,
        FK_LONG_BY_ONE,
        FK_OVERLONG,
        FK_NOISE
    } frame_kind_t;

    // tracks the receiver's view of the frame and queues the words it owes
    class frame_scoreboard #(int NCH = 8);
        logic [7:0]  head_req, type_req, version_req, flag_mask;
        logic [5:0]  byte_pos;
        logic [15:0] crc_acc;
        logic [7:0]  lag_bytes [2];
        bit          header_ok;
        logic [7:0]  flags_hold;
        logic [31:0] boot_hold, session_hold, seq_hold;
        logic [15:0] offsets [NCH];
        cfr_pkg::cfr_out_t pending_words [$];
        int          errors;

        function new();
            head_req = 8'h00;
            type_req = 8'h00;
            version_req = 8'h00;
            flag_mask = 8'h01;
            flags_hold = '0;
            boot_hold = '0;
            session_hold = '0;
            seq_hold = '0;
            foreach (offsets[i]) offsets[i] = '0;
            errors = 0;
            restart_frame();
        endfunction

        static function logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb = crc[15] ^ b[i];
                crc = crc << 1;
                if (fb) crc = crc ^ cfr_pkg::CRC_POLY;
            end
            return crc;
        endfunction

        function void restart_frame();
            byte_pos = '0;
            crc_acc = cfr_pkg::CRC_INIT;
            lag_bytes[0] = '0;
            lag_bytes[1] = '0;
            header_ok = 1'b1;
        endfunction

        function void set_register(cfr_pkg::cfr_reg_index_t idx, logic [7:0] val);
            case (idx)
                cfr_pkg::REG_HEAD:    head_req = val;
                cfr_pkg::REG_TYPE:    type_req = val;
                cfr_pkg::REG_VERSION: version_req = val;
                cfr_pkg::REG_FLAGS:   flag_mask = val;
                default: ;
            endcase
        endfunction

        function void note_byte(cfr_pkg::cfr_in_t w);
            int pos;
            int ch;
            logic [7:0] b;
            logic [15:0] rx_crc;
            cfr_pkg::cfr_out_t word;
            b = w.data_byte;
            pos = byte_pos;
            // crc runs two bytes behind so the trailing crc bytes stay out of it
            if (pos >= 2) crc_acc = crc_next(crc_acc, lag_bytes[0]);
            lag_bytes[0] = lag_bytes[1];
            lag_bytes[1] = b;
            if (pos == 0 && b != head_req) header_ok = 1'b0;
            if (pos == 1 && b != type_req) header_ok = 1'b0;
            if (pos == 2 && b != version_req) header_ok = 1'b0;
            if (pos == 3) begin
                if ((b & ~flag_mask) != 8'h00) header_ok = 1'b0;
                flags_hold = b;
            end
            if (pos >= 4 && pos < 8) begin
                boot_hold[8*(pos-4) +: 8] = b;
            end else if (pos >= 8 && pos < 12) begin
                session_hold[8*(pos-8) +: 8] = b;
            end else if (pos >= 12 && pos < 16) begin
                seq_hold[8*(pos-12) +: 8] = b;
            end else if (pos >= 16) begin
                ch = (pos - 16) >> 1;
                if (ch < NCH) begin
                    if (((pos - 16) & 1) == 0) offsets[ch][7:0] = b;
                    else offsets[ch][15:8] = b;
                end
            end
            if (pos < cfr_pkg::POS_MAX) pos++;
            byte_pos = 6'(pos);
            if (!w.frame_end) return;

            rx_crc = {lag_bytes[1], lag_bytes[0]};
            if (pos != 18 + 2*NCH || !header_ok || rx_crc != crc_acc) begin
                word = '0;
                word.last_result = 1'b1;
                pending_words.push_back(word);
            end else begin
                for (int i = 0; i < NCH; i++) begin
                    word.accepted = 1'b1;
                    word.flag_bits = flags_hold;
                    word.boot_ident = boot_hold;
                    word.session_ident = session_hold;
                    word.sequence_number = seq_hold;
                    word.channel_index = 4'(i);
                    word.channel_offset = offsets[i];
                    word.last_result = (i == NCH - 1);
                    pending_words.push_back(word);
                end
            end
            restart_frame();
        endfunction

        function string word_text(cfr_pkg::cfr_out_t w);
            return $sformatf({"acc=%0b flags=%02h boot=%08h sess=%08h seq=%08h",
                              " ch=%0d off=%04h last=%0b"},
                             w.accepted, w.flag_bits, w.boot_ident, w.session_ident,
                             w.sequence_number, w.channel_index, w.channel_offset,
                             w.last_result);
        endfunction

        function void check_word(cfr_pkg::cfr_out_t got);
            cfr_pkg::cfr_out_t want;
            if (pending_words.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word: %s", word_text(got));
                return;
            end
            want = pending_words.pop_front();
            if (got.accepted !== want.accepted || got.flag_bits !== want.flag_bits ||
                got.boot_ident !== want.boot_ident ||
                got.session_ident !== want.session_ident ||
                got.sequence_number !== want.sequence_number ||
                got.channel_index !== want.channel_index ||
                got.channel_offset !== want.channel_offset ||
                got.last_result !== want.last_result) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch at %0t", $realtime);
                    $display("  expected %s", word_text(want));
                    $display("  actual   %s", word_text(got));
                end
            end
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cfr_pkg::cfr_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cfr_pkg::cfr_out_t m_data;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_wr_data = '0;

    frame_scoreboard #(CHANNELS) sb;
    logic [7:0] reg_shadow [4] = '{8'h00, 8'h00, 8'h00, 8'h01};
    logic [7:0] frame_buf [$];
    bit calm = 1'b0;
    int bytes_sent = 0;
    int ready_hold = 0;

    command_frame_receiver #(
        .CHANNELS(CHANNELS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: check on handshake, then pick the next ready pattern
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_word(m_data);
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (calm || $urandom_range(0, 2) != 0) begin
            m_ready <= 1'b1;
            ready_hold = $urandom_range(0, 7);
        end else begin
            m_ready <= 1'b0;
            ready_hold = idle_cycles();
        end
    end

    task automatic send_word(input logic [7:0] b, input logic fin);
        int gap;
        cfr_pkg::cfr_in_t w;
        gap = idle_cycles();
        w.data_byte = b;
        w.frame_end = fin;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(s_data);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) send_word(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge aclk);
        // a word may still be on its way out of the receiver
        repeat (2*CHANNELS + 4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfr_pkg::cfr_reg_index_t idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        sb.set_register(idx, val);
        reg_shadow[idx] = val;
    endtask

    task automatic build_frame(input frame_kind_t kind);
        logic [7:0]  flags;
        logic [7:0]  mask;
        logic [15:0] crc;
        logic [15:0] off;
        logic [31:0] field32;
        int n;
        frame_buf.delete();
        if (kind == FK_OVERLONG || kind == FK_NOISE) begin
            n = (kind == FK_OVERLONG) ? $urandom_range(64, 80) : $urandom_range(1, 40);
            repeat (n) frame_buf.push_back(8'($urandom()));
            return;
        end
        mask = reg_shadow[cfr_pkg::REG_FLAGS];
        flags = 8'($urandom()) & mask;
        if ($urandom_range(0, 3) == 0) flags = mask;
        if (kind == FK_BAD_FLAGS && mask != 8'hFF) begin
            do n = $urandom_range(1, 255); while ((8'(n) & ~mask) == 8'h00);
            flags = flags | (8'(n) & ~mask);
        end
        frame_buf.push_back(reg_shadow[cfr_pkg::REG_HEAD]);
        frame_buf.push_back(reg_shadow[cfr_pkg::REG_TYPE]);
        frame_buf.push_back(reg_shadow[cfr_pkg::REG_VERSION]);
        frame_buf.push_back(flags);
        // boot, session and sequence, little-endian
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 7))
                0:       field32 = 32'hFFFF_FFFF;
                1:       field32 = 32'h0000_0000;
                default: field32 = $urandom();
            endcase
            for (int j = 0; j < 4; j++) frame_buf.push_back(field32[8*j +: 8]);
        end
        for (int ch = 0; ch < CHANNELS; ch++) begin
            case ($urandom_range(0, 5))
                0:       off = 16'h8000;
                1:       off = 16'h7FFF;
                2:       off = 16'hFFFF;
                3:       off = 16'h0000;
                default: off = 16'($urandom());
            endcase
            frame_buf.push_back(off[7:0]);
            frame_buf.push_back(off[15:8]);
        end
        if (kind == FK_LONG_BY_ONE) frame_buf.push_back(8'($urandom()));
        case (kind)
            FK_BAD_HEAD:    frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
            FK_BAD_TYPE:    frame_buf[1] = frame_buf[1] ^ 8'($urandom_range(1, 255));
            FK_BAD_VERSION: frame_buf[2] = frame_buf[2] ^ 8'($urandom_range(1, 255));
            default: ;
        endcase
        crc = cfr_pkg::CRC_INIT;
        foreach (frame_buf[i]) crc = sb.crc_next(crc, frame_buf[i]);
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
        // with every flag allowed there is no bad flag, so spoil the crc instead
        if (kind == FK_BAD_CRC || (kind == FK_BAD_FLAGS && mask == 8'hFF)) begin
            n = frame_buf.size() - 1 - $urandom_range(0, 1);
            frame_buf[n] = frame_buf[n] ^ 8'(1 << $urandom_range(0, 7));
        end
        if (kind == FK_SHORT) begin
            n = $urandom_range(1, frame_buf.size() - 1);
            repeat (n) void'(frame_buf.pop_back());
        end
    endtask

    initial begin
        int phase_start;
        int fidx;
        int r;
        frame_kind_t kind;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short frames against the reset register values
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h01, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        drain_results();

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                for (int k = 0; k < 4; k++) begin
                    case (phase)
                        1:       write_reg(cfr_pkg::cfr_reg_index_t'(k), 8'hFF);
                        2:       write_reg(cfr_pkg::cfr_reg_index_t'(k), 8'h00);
                        default: write_reg(cfr_pkg::cfr_reg_index_t'(k), 8'($urandom()));
                    endcase
                end
                cfg_wr_en <= 1'b0;
            end
            phase_start = bytes_sent;
            fidx = 0;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                calm = ($urandom_range(0, 5) == 0);
                if (fidx == 0) begin
                    kind = FK_GOOD;
                end else if (fidx < 3) begin
                    kind = frame_kind_t'(1 + (2*phase + fidx - 1) % 9);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 55)      kind = FK_GOOD;
                    else if (r < 60) kind = FK_BAD_HEAD;
                    else if (r < 65) kind = FK_BAD_TYPE;
                    else if (r < 70) kind = FK_BAD_VERSION;
                    else if (r < 75) kind = FK_BAD_FLAGS;
                    else if (r < 82) kind = FK_BAD_CRC;
                    else if (r < 88) kind = FK_SHORT;
                    else if (r < 92) kind = FK_LONG_BY_ONE;
                    else if (r < 95) kind = FK_OVERLONG;
                    else             kind = FK_NOISE;
                end
                build_frame(kind);
                send_frame();
                fidx++;
                // hold the sender off until the receiver has caught up
                if (fidx == 1 || $urandom_range(0, 7) == 0) drain_results();
            end
            calm = 1'b0;
            drain_results();
        end

        repeat (2*CHANNELS + 10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cfr_pkg.sv
rtl/core/cfr_offset_ram.sv
rtl/core/command_frame_receiver.sv
sim/command_frame_receiver_tb.sv
